@@ sv/socs_pkg.sv @@
package socs_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam logic [31:0] ALWAYS_VISIBLE = 32'h1000_0000;
    localparam logic [5:0]  RESULT_LIMIT   = 6'd32;

    // configuration register indexes
    localparam logic CFG_CAMERA_ZONE = 1'b0;
    localparam logic CFG_ENTRIES     = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [4:0]         entry_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [22:0]        sphere_radius;
        logic [31:0]        zone_mask;
        logic [5:0]         max_matches;
    } t_in_word;

    typedef struct packed {
        logic       found;
        logic [4:0] match_index;
        logic [5:0] match_count;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        logic [22:0]        rad;
        logic [31:0]        zone;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // token travelling down the walk pipeline alongside the entry data
    typedef struct packed {
        logic       vld;
        logic       fin;
        logic [4:0] idx;
    } t_tok;

    // query sphere and camera mask held for the duration of a walk
    typedef struct packed {
        logic signed [23:0] qx;
        logic signed [23:0] qy;
        logic signed [23:0] qz;
        logic [22:0]        qr;
        logic [31:0]        cam;
    } t_query;

endpackage

@@ sv/socs_stream_if.sv @@
interface socs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/socs_ram.sv @@
module socs_ram #(
    parameter int DEPTH = socs_pkg::MAX_ENTRIES_DEF,
    parameter int WIDTH = socs_pkg::ENTRY_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/socs_match.sv @@
module socs_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_flush,
    input  socs_pkg::t_tok    i_tok,
    input  socs_pkg::t_entry  i_entry,
    input  socs_pkg::t_query  i_query,
    output socs_pkg::t_tok    o_tok,
    output logic              o_match
);
    socs_pkg::t_tok r_tb, r_tc, r_td, r_te;

    logic signed [24:0] r_dx, r_dy, r_dz;
    logic [23:0]        r_rsum;
    logic               r_zok_b, r_zok_c, r_zok_d;
    logic [48:0]        r_sx, r_sy, r_sz_c, r_sz_d;
    logic [47:0]        r_rsq_c, r_rsq_d;
    logic [49:0]        r_sxy;
    logic               r_match;

    logic signed [49:0] px, py, pz;
    logic               zone_ok;
    logic [50:0]        dist2;

    assign zone_ok = ((i_entry.zone & socs_pkg::ALWAYS_VISIBLE) != 32'd0) ||
                     ((i_query.cam & i_entry.zone) == i_query.cam);
    assign px = 50'(r_dx) * 50'(r_dx);
    assign py = 50'(r_dy) * 50'(r_dy);
    assign pz = 50'(r_dz) * 50'(r_dz);
    assign dist2 = {1'b0, r_sxy} + {2'b00, r_sz_d};

    always_ff @(posedge i_clk) begin
        // token valids
        if (!i_rst_n || i_flush) begin
            r_tb.vld <= 1'b0;
            r_tc.vld <= 1'b0;
            r_td.vld <= 1'b0;
            r_te.vld <= 1'b0;
        end else if (i_en) begin
            r_tb.vld <= i_tok.vld;
            r_tc.vld <= r_tb.vld;
            r_td.vld <= r_tc.vld;
            r_te.vld <= r_td.vld;
        end
        if (i_en) begin
            // differences and radius sum
            r_tb.fin <= i_tok.fin;
            r_tb.idx <= i_tok.idx;
            r_dx     <= {i_query.qx[23], i_query.qx} - {i_entry.cx[23], i_entry.cx};
            r_dy     <= {i_query.qy[23], i_query.qy} - {i_entry.cy[23], i_entry.cy};
            r_dz     <= {i_query.qz[23], i_query.qz} - {i_entry.cz[23], i_entry.cz};
            r_rsum   <= {1'b0, i_query.qr} + {1'b0, i_entry.rad};
            r_zok_b  <= zone_ok;
            // squares
            r_tc.fin <= r_tb.fin;
            r_tc.idx <= r_tb.idx;
            r_sx     <= px[48:0];
            r_sy     <= py[48:0];
            r_sz_c   <= pz[48:0];
            r_rsq_c  <= 48'(r_rsum) * 48'(r_rsum);
            r_zok_c  <= r_zok_b;
            // partial sum
            r_td.fin <= r_tc.fin;
            r_td.idx <= r_tc.idx;
            r_sxy    <= {1'b0, r_sx} + {1'b0, r_sy};
            r_sz_d   <= r_sz_c;
            r_rsq_d  <= r_rsq_c;
            r_zok_d  <= r_zok_c;
            // final sum and compare
            r_te.fin <= r_td.fin;
            r_te.idx <= r_td.idx;
            r_match  <= r_zok_d && (dist2 <= {3'b000, r_rsq_d});
        end
    end

    assign o_tok   = r_te;
    assign o_match = r_match;
endmodule

@@ sv/sphere_overlap_cull_table_top.sv @@
// Sphere overlap table with culling by zone.
// Input channel i_in carries one word per item. A word with kind clear writes
// the entry named by entry_index; it gives no result. A word with kind set is a
// query: the entries 0 .. entries_in_use-1, capped at MAX_ENTRIES-1, are read
// from the entry memory one per cycle and each is tested for zone and overlap.
// Output channel o_out carries one word per reported match, in index order,
// the final one flagged by last; a query with no report gives one word with
// found clear and last set.
// A query passes one memory read per entry, a four-stage distance pipeline and
// the report stage, which holds each match back until the next match or the end
// of the walk decides last. The first result goes through the issue register, the
// memory read, the four distance stages and the output register. No new item is
// taken until the query's last word has been placed in the output register.
// A stall on o_out freezes the read port and the whole pipeline in place.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
// Reset clears the configuration, busy and valid flags and the match count; the entry
// memory is not cleared and an entry must be written before a query reads it.
module sphere_overlap_cull_table_top #(
    parameter int MAX_ENTRIES = socs_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    socs_stream_if.sink   i_in,
    socs_stream_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    socs_pkg::t_in_word  in_word;
    socs_pkg::t_out_word r_out_word, emit_word;
    socs_pkg::t_entry    rd_entry, wr_entry;
    socs_pkg::t_query    r_query;
    socs_pkg::t_tok      iss_tok, r_a_tok, e_tok;

    logic [31:0]   r_cam;
    logic [5:0]    r_eiu;
    logic          r_busy, r_issuing, r_out_valid;
    logic [CW-1:0] r_iss_cnt, r_walk;
    logic [5:0]    r_limit, r_rep, n_rep;
    logic          r_pv, n_pv;
    logic [4:0]    r_pi, n_pi;

    logic          in_acc, adv, emit, done, flush, e_match, wr_en;
    logic [31:0]   cnt_w, widx_w;
    logic [socs_pkg::ENTRY_BITS-1:0] rd_bits;

    assign in_word = i_in.data;
    assign in_acc  = i_in.valid && i_in.ready;
    assign adv     = !r_out_valid || o_out.ready;

    assign i_in.ready  = !r_busy;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= '0;
            r_eiu <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                socs_pkg::CFG_CAMERA_ZONE: r_cam <= i_cfg_data;
                socs_pkg::CFG_ENTRIES:     r_eiu <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // entry memory
    assign widx_w   = 32'(in_word.entry_index);
    assign wr_en    = in_acc && !in_word.kind && (widx_w < 32'(MAX_ENTRIES));
    assign wr_entry = '{cx: in_word.pos_x, cy: in_word.pos_y, cz: in_word.pos_z,
                        rad: in_word.sphere_radius, zone: in_word.zone_mask};
    assign cnt_w    = 32'(r_iss_cnt);

    socs_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (socs_pkg::ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (widx_w[AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (adv),
        .i_raddr (cnt_w[AW-1:0]),
        .o_rdata (rd_bits)
    );
    assign rd_entry = rd_bits;

    // issue one entry per cycle while the output is not stalled, then a closing token
    assign iss_tok = '{vld: r_issuing, fin: (r_iss_cnt == r_walk), idx: cnt_w[4:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_a_tok   <= '0;
        end else begin
            if (in_acc && in_word.kind) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
            end else if (flush) begin
                r_busy    <= 1'b0;
                r_issuing <= 1'b0;
            end else if (adv && r_issuing && iss_tok.fin) begin
                r_issuing <= 1'b0;
            end
            if (flush) begin
                r_a_tok.vld <= 1'b0;
            end else if (adv) begin
                r_a_tok <= iss_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_word.kind) begin
            r_iss_cnt <= '0;
            r_walk    <= (32'(r_eiu) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(r_eiu);
            r_limit   <= (in_word.max_matches > socs_pkg::RESULT_LIMIT) ?
                         socs_pkg::RESULT_LIMIT : in_word.max_matches;
            r_query   <= '{qx: in_word.pos_x, qy: in_word.pos_y, qz: in_word.pos_z,
                           qr: in_word.sphere_radius, cam: r_cam};
        end else if (adv && r_issuing && !iss_tok.fin) begin
            r_iss_cnt <= r_iss_cnt + CW'(1);
        end
    end

    socs_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_flush (flush),
        .i_tok   (r_a_tok),
        .i_entry (rd_entry),
        .i_query (r_query),
        .o_tok   (e_tok),
        .o_match (e_match)
    );

    // report: hold each match until the next event decides whether it is last
    always_comb begin
        emit      = 1'b0;
        done      = 1'b0;
        emit_word = '0;
        n_pv      = r_pv;
        n_pi      = r_pi;
        n_rep     = r_rep;
        if (e_tok.vld) begin
            if (e_tok.fin || (e_match && (r_rep == r_limit))) begin
                emit = 1'b1;
                done = 1'b1;
                emit_word.last = 1'b1;
                if (r_pv) begin
                    emit_word.found       = 1'b1;
                    emit_word.match_index = r_pi;
                    emit_word.match_count = r_rep;
                end
            end else if (e_match) begin
                if (r_pv) begin
                    emit = 1'b1;
                    emit_word.found       = 1'b1;
                    emit_word.match_index = r_pi;
                    emit_word.match_count = r_rep;
                end
                n_pv  = 1'b1;
                n_pi  = e_tok.idx;
                n_rep = r_rep + 6'd1;
            end
        end
    end

    assign flush = adv && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_rep       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (in_acc && in_word.kind) begin
                r_pv  <= 1'b0;
                r_rep <= '0;
            end else if (adv) begin
                r_pv  <= n_pv;
                r_rep <= n_rep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= emit_word;
            r_pi       <= n_pi;
        end
    end

    a_notfound_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.found || o_out.data.last))
        else $error("result without a match is not flagged last");

    a_count_matches_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.found == (o_out.data.match_count != 6'd0)))
        else $error("match count disagrees with found");

    a_rep_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rep <= r_limit))
        else $error("more matches held than the limit allows");

    a_issue_within_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_iss_cnt <= r_walk))
        else $error("walk counter ran past the walk length");

    a_issue_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> r_busy)
        else $error("entry reads issued outside a query");
endmodule

@@ tb/sv/tb_sphere_overlap_cull_table_top.sv @@
`timescale 1ns / 1ps

module tb_sphere_overlap_cull_table_top;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;

    localparam socs_pkg::t_out_word NO_HIT = '{found: 1'b0, match_index: 5'd0,
                                               match_count: 6'd0, last: 1'b1};

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_WORD, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op             op;
        socs_pkg::t_in_word  w;
        logic                cfg_idx;
        logic [31:0]         cfg_val;
        bit                  typed;
        socs_pkg::t_out_word want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    socs_stream_if #(.T(socs_pkg::t_in_word))  in_if ();
    socs_stream_if #(.T(socs_pkg::t_out_word)) out_if ();

    sphere_overlap_cull_table_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the table and registers
    logic signed [23:0] ent_x    [socs_pkg::MAX_ENTRIES_DEF];
    logic signed [23:0] ent_y    [socs_pkg::MAX_ENTRIES_DEF];
    logic signed [23:0] ent_z    [socs_pkg::MAX_ENTRIES_DEF];
    logic [22:0]        ent_r    [socs_pkg::MAX_ENTRIES_DEF];
    logic [31:0]        ent_zone [socs_pkg::MAX_ENTRIES_DEF];
    logic [31:0]        cam_mask;
    logic [5:0]         walk_len;

    socs_pkg::t_out_word hits_due [$];
    int                  mismatch_count;
    int unsigned         src_pct;
    int unsigned         sink_pct;
    bit                  hold_go;
    int                  cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint sq_gap(input logic signed [23:0] a, input logic signed [23:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic bit zone_pass(input logic [31:0] z);
        return ((z & socs_pkg::ALWAYS_VISIBLE) != 32'd0) || ((cam_mask & z) == cam_mask);
    endfunction

    // append a word to the expected results
    function automatic void queue_due(input socs_pkg::t_out_word o);
        hits_due.insert(hits_due.size(), o);
    endfunction

    // store a written entry, or work out the words a query reports
    function automatic void overlap_walk(input socs_pkg::t_in_word w);
        socs_pkg::t_out_word hits [$];
        socs_pkg::t_out_word o;
        int        walk;
        int        lim;
        longint    d2;
        longint    rs;
        if (!w.kind) begin
            ent_x[w.entry_index]    = w.pos_x;
            ent_y[w.entry_index]    = w.pos_y;
            ent_z[w.entry_index]    = w.pos_z;
            ent_r[w.entry_index]    = w.sphere_radius;
            ent_zone[w.entry_index] = w.zone_mask;
            return;
        end
        lim  = (w.max_matches > socs_pkg::RESULT_LIMIT) ? int'(socs_pkg::RESULT_LIMIT) :
                                                          int'(w.max_matches);
        walk = (walk_len > socs_pkg::MAX_ENTRIES_DEF) ? socs_pkg::MAX_ENTRIES_DEF :
                                                        int'(walk_len);
        for (int i = 0; i < walk; i++) begin
            if (!zone_pass(ent_zone[i]))
                continue;
            d2 = sq_gap(w.pos_x, ent_x[i]) + sq_gap(w.pos_y, ent_y[i]) +
                 sq_gap(w.pos_z, ent_z[i]);
            rs = longint'(w.sphere_radius) + longint'(ent_r[i]);
            if (d2 > rs * rs)
                continue;
            // stop at the first match beyond the limit
            if (hits.size() >= lim)
                break;
            o.found       = 1'b1;
            o.match_index = 5'(i);
            o.match_count = 6'(hits.size() + 1);
            o.last        = 1'b0;
            hits.insert(hits.size(), o);
        end
        if (hits.size() == 0) begin
            queue_due(NO_HIT);
        end else begin
            foreach (hits[k]) begin
                o      = hits[k];
                o.last = (k == hits.size() - 1);
                queue_due(o);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input socs_pkg::t_out_word got,
                                   input socs_pkg::t_out_word want);
        $display("mismatch %s at %0t: got f=%0d i=%0d c=%0d l=%0d want f=%0d i=%0d c=%0d l=%0d",
                 what, $time, got.found, got.match_index, got.match_count, got.last,
                 want.found, want.match_index, want.match_count, want.last);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        socs_pkg::t_out_word got;
        socs_pkg::t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (hits_due.size() == 0) begin
                report_mismatch("unexpected word", got, '0);
            end else begin
                want = hits_due.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got, want);
                if (got.match_index !== want.match_index)
                    report_mismatch("match_index", got, want);
                if (got.match_count !== want.match_count)
                    report_mismatch("match_count", got, want);
                if (got.last !== want.last)
                    report_mismatch("last", got, want);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_pct);
            end
        end
    end

    task automatic offer_word(input socs_pkg::t_in_word w, input bit typed,
                              input socs_pkg::t_out_word want);
        in_if.data  <= w;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (typed)
            queue_due(want);
        else
            overlap_walk(w);
    endtask

    task automatic sender_gap();
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // writes give no word back, so allow the block to finish before touching registers
    task automatic drain_and_settle();
        in_if.valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == socs_pkg::CFG_CAMERA_ZONE)
            cam_mask = val;
        else
            walk_len = val[5:0];
        @(posedge i_clk);
    endtask

    function automatic t_dir_row wr_row(input logic [4:0] idx, input logic [23:0] x,
                                        input logic [23:0] y, input logic [23:0] z,
                                        input logic [22:0] r, input logic [31:0] zn);
        t_dir_row row;
        row.op      = ROW_WORD;
        row.w       = '{kind: 1'b0, entry_index: idx, pos_x: x, pos_y: y, pos_z: z,
                        sphere_radius: r, zone_mask: zn, max_matches: 6'd0};
        row.cfg_idx = socs_pkg::CFG_CAMERA_ZONE;
        row.cfg_val = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_dir_row q_row(input logic [23:0] x, input logic [23:0] y,
                                       input logic [23:0] z, input logic [22:0] r,
                                       input logic [5:0] lim, input bit typed,
                                       input socs_pkg::t_out_word want);
        t_dir_row row;
        row       = wr_row(5'd0, x, y, z, r, 32'd0);
        row.w.kind        = 1'b1;
        row.w.max_matches = lim;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic idx, input logic [31:0] val);
        t_dir_row row;
        row         = wr_row(5'd0, '0, '0, '0, '0, '0);
        row.op      = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic logic [23:0] rand_coord();
        if ($urandom_range(9) < 3)
            return 24'($urandom);
        return 24'($urandom_range(32'h8000)) - 24'h004000;
    endfunction

    function automatic logic [22:0] rand_radius();
        if ($urandom_range(9) < 3)
            return 23'($urandom);
        return 23'($urandom_range(32'h3000));
    endfunction

    function automatic logic [31:0] rand_zone();
        case ($urandom_range(3))
            0:       return socs_pkg::ALWAYS_VISIBLE | $urandom;
            1:       return 32'hFFFF_FFFF;
            2:       return cam_mask | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] rand_limit();
        case ($urandom_range(9))
            0, 1, 2: return 6'($urandom_range(1, 3));
            3:       return 6'($urandom_range(33, 63));
            default: return 6'($urandom_range(0, 32));
        endcase
    endfunction

    function automatic socs_pkg::t_in_word random_word(input bit is_query);
        socs_pkg::t_in_word w;
        w.kind          = is_query;
        w.entry_index   = 5'($urandom_range(31));
        w.pos_x         = rand_coord();
        w.pos_y         = rand_coord();
        w.pos_z         = rand_coord();
        w.sphere_radius = rand_radius();
        w.zone_mask     = rand_zone();
        w.max_matches   = rand_limit();
        return w;
    endfunction

    initial begin
        t_dir_row           rows [$];
        socs_pkg::t_in_word w;
        logic [31:0]        cam;
        logic [5:0]         ent;
        t_idle_mode         mode;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= socs_pkg::CFG_CAMERA_ZONE;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        src_pct        = 0;
        sink_pct       = 0;
        hold_go        = 1'b0;
        cam_mask       = '0;
        walk_len       = '0;

        // nothing walked straight after reset
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h100, 6'd5, 1'b1, NO_HIT));
        rows.insert(rows.size(), wr_row(5'd0, 24'h0, 24'h0, 24'h0, 23'h100,
                                        socs_pkg::ALWAYS_VISIBLE));
        rows.insert(rows.size(), wr_row(5'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
                                        32'hFFFF_FFFF));
        rows.insert(rows.size(), wr_row(5'd2, 24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF,
                                        32'h0));
        rows.insert(rows.size(), wr_row(5'd3, 24'h000100, 24'h0, 24'h0, 23'h0, 32'h0000_00F0));
        rows.insert(rows.size(), wr_row(5'd31, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF,
                                        32'hEFFF_FFFF));
        rows.insert(rows.size(), cfg_row(socs_pkg::CFG_ENTRIES, 32'd4));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h0, 6'd32, 1'b0, '0));
        // spheres that just touch
        rows.insert(rows.size(), q_row(24'h000200, 24'h0, 24'h0, 23'h100, 6'd32, 1'b0, '0));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h7FFFFF, 6'd0, 1'b1, NO_HIT));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h7FFFFF, 6'd1, 1'b1,
                                       '{1'b1, 5'd0, 6'd1, 1'b1}));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h7FFFFF, 6'd63, 1'b0, '0));
        rows.insert(rows.size(), q_row(24'h800000, 24'h800000, 24'h800000, 23'h0, 6'd32,
                                       1'b0, '0));
        rows.insert(rows.size(), q_row(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 6'd2,
                                       1'b0, '0));
        rows.insert(rows.size(), q_row(24'h7FFFFF, 24'h800000, 24'h0, 23'h0, 6'd32, 1'b0, '0));
        rows.insert(rows.size(), cfg_row(socs_pkg::CFG_CAMERA_ZONE, 32'hFFFF_FFFF));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h7FFFFF, 6'd32, 1'b0, '0));
        rows.insert(rows.size(), cfg_row(socs_pkg::CFG_CAMERA_ZONE, 32'h0000_0010));
        rows.insert(rows.size(), q_row(24'h0, 24'h0, 24'h0, 23'h7FFFFF, 6'd32, 1'b0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].op == ROW_CFG) begin
                drain_and_settle();
                write_reg(rows[k].cfg_idx, rows[k].cfg_val);
            end else begin
                offer_word(rows[k].w, rows[k].typed, rows[k].want);
            end
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin cam = 32'h0;            ent = 6'd32; mode = IDLE_NONE;     end
                1:       begin cam = 32'hFFFF_FFFF;    ent = 6'd63; mode = IDLE_SENDER;   end
                2:       begin cam = $urandom & $urandom;
                               ent = 6'($urandom_range(2, 32));   mode = IDLE_RECEIVER; end
                3:       begin cam = 32'h0000_0001;    ent = 6'd1;  mode = IDLE_BOTH;     end
                4:       begin cam = $urandom;
                               ent = 6'($urandom_range(33, 63));  mode = IDLE_RECEIVER; end
                default: begin cam = $urandom & $urandom & $urandom;
                               ent = 6'($urandom_range(2, 32));   mode = IDLE_SENDER;   end
            endcase
            drain_and_settle();
            write_reg(socs_pkg::CFG_CAMERA_ZONE, cam);
            write_reg(socs_pkg::CFG_ENTRIES, {26'd0, ent});
            src_pct  = (mode == IDLE_SENDER)   ? 71 : (mode == IDLE_BOTH) ? 30 : 0;
            sink_pct = (mode == IDLE_RECEIVER) ? 71 : (mode == IDLE_BOTH) ? 30 : 0;

            // fill every entry before any query can walk past the written ones
            if (p == 0) begin
                for (int e = 0; e < socs_pkg::MAX_ENTRIES_DEF; e++) begin
                    w             = random_word(1'b0);
                    w.entry_index = 5'(e);
                    offer_word(w, 1'b0, '0);
                end
            end
            // hold the receiver off while words keep coming, so the block backs up
            if (p == 2)
                hold_go = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_gap();
                offer_word(random_word($urandom_range(3) != 0), 1'b0, '0);
            end
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
